### rtl/plist_pkg.sv
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and codes for the positional insert/remove list.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 4;
  localparam int OCC_W  = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // Broadcast to every cell in the row
  typedef struct packed {
    logic                     do_ins;
    logic                     do_rem;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] new_value;
  } cell_ctl_t;

endpackage

### rtl/plist_cell.sv
// ----------------------------------------------------------------------------
// plist_cell
// One list slot: holds a word, loads the new word, or takes a neighbor's word.
// ----------------------------------------------------------------------------
module plist_cell import plist_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [WORD_W-1:0] left_value,
  input  logic signed [WORD_W-1:0] right_value,
  output logic signed [WORD_W-1:0] value
);

  localparam logic [31:0] MY_IDX = 32'(IDX);

  logic [31:0]              pos_w;
  logic signed [WORD_W-1:0] value_r;
  logic signed [WORD_W-1:0] value_nxt;

  assign pos_w = 32'(ctl.pos);

  always_comb begin
    value_nxt = value_r;
    if (ctl.do_ins) begin
      if (MY_IDX > pos_w) begin
        value_nxt = left_value;
      end else if (MY_IDX == pos_w) begin
        value_nxt = ctl.new_value;
      end
    end else if (ctl.do_rem) begin
      // close the gap: everything at or after the position moves down
      if (MY_IDX >= pos_w) begin
        value_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

### rtl/positional_insert_remove_list_core.sv
// ----------------------------------------------------------------------------
// positional_insert_remove_list_core
// Ordered list of signed words in a row of shifting cells, with insert and
// remove at any position and one status word per operation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | opcode, position, new_value
//  out_    | output    | out_valid/out_ready | ok, taken_value, front_value,
//          |           |                     | back_value, occupancy,
//          |           |                     | is_empty, is_full
//
// One operation per cycle if not stalled: every cell compares its index with
// the position and shifts in the same cycle; the status word is out in the
// cycle after accept. in_ready is high while the output register is empty or
// being drained, so a stalled output holds the list and everything behind it.
// Reset clears the occupancy and the output valid; cell contents are not reset.
// ----------------------------------------------------------------------------
module positional_insert_remove_list_core import plist_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_opcode,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [WORD_W-1:0] in_new_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_ok,
  output logic signed [WORD_W-1:0] out_taken_value,
  output logic signed [WORD_W-1:0] out_front_value,
  output logic signed [WORD_W-1:0] out_back_value,
  output logic [OCC_W-1:0]         out_occupancy,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  logic signed [WORD_W-1:0] cell_val [DEPTH];
  cell_ctl_t                ctl;
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic                     out_valid_r;
  logic                     ok_r;
  logic                     ok_nxt;
  logic signed [WORD_W-1:0] taken_r;
  logic signed [WORD_W-1:0] taken_nxt;
  logic signed [WORD_W-1:0] taken_sel;
  logic signed [WORD_W-1:0] back_sel;
  logic [CMP_W-1:0]         pos_c;
  logic [CMP_W-1:0]         cnt_c;
  logic                     accept;
  logic                     ins_ok;
  logic                     rem_ok;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign pos_c    = CMP_W'(in_position);
  assign cnt_c    = CMP_W'(count_r);

  assign ins_ok = (op_t'(in_opcode) == OP_INSERT) && (count_r < CW'(DEPTH)) &&
                  (pos_c <= cnt_c);
  assign rem_ok = (op_t'(in_opcode) == OP_REMOVE) && (count_r != '0) &&
                  (pos_c < cnt_c);

  assign ctl.do_ins    = accept && ins_ok;
  assign ctl.do_rem    = accept && rem_ok;
  assign ctl.pos       = in_position;
  assign ctl.new_value = in_new_value;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      plist_cell #(.IDX(g)) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .left_value ((g == 0) ? in_new_value : cell_val[(g == 0) ? 0 : g - 1]),
        .right_value((g == DEPTH - 1) ? cell_val[g] :
                     cell_val[(g == DEPTH - 1) ? g : g + 1]),
        .value      (cell_val[g])
      );
    end
  endgenerate

  // AND-OR picks: the word under the position, and the word at the tail
  always_comb begin
    taken_sel = '0;
    back_sel  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (32'(in_position) == 32'(i)) begin
        taken_sel = taken_sel | cell_val[i];
      end
      if (32'(count_r) == 32'(i + 1)) begin
        back_sel = back_sel | cell_val[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    ok_nxt    = ok_r;
    taken_nxt = taken_r;
    if (accept) begin
      ok_nxt    = ins_ok || rem_ok;
      taken_nxt = rem_ok ? taken_sel : '0;
      if (ins_ok) begin
        count_nxt = count_r + CW'(1);
      end else if (rem_ok) begin
        count_nxt = count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ok_r    <= ok_nxt;
    taken_r <= taken_nxt;
  end

  // List state only moves on accept, so it always matches the held word
  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_taken_value = taken_r;
  assign out_front_value = (count_r != '0) ? cell_val[0] : '0;
  assign out_back_value  = back_sel;
  assign out_occupancy   = OCC_W'(count_r);
  assign out_is_empty    = (count_r == '0);
  assign out_is_full     = (count_r == CW'(DEPTH));

endmodule

### rtl/plist_chk.sv
// ----------------------------------------------------------------------------
// plist_chk
// Port-level checks for the positional insert/remove list.
// ----------------------------------------------------------------------------
module plist_chk import plist_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_opcode,
  input logic [POS_W-1:0]         in_position,
  input logic signed [WORD_W-1:0] in_new_value,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     out_ok,
  input logic signed [WORD_W-1:0] out_taken_value,
  input logic signed [WORD_W-1:0] out_front_value,
  input logic signed [WORD_W-1:0] out_back_value,
  input logic [OCC_W-1:0]         out_occupancy,
  input logic                     out_is_empty,
  input logic                     out_is_full
);

  // every accepted word gives a status word on the next cycle
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_taken_value == '0)
    else $error("refused operation returned a taken value");

  a_empty_view: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_occupancy == '0 && out_front_value == '0 &&
                                  out_back_value == '0 && !out_is_full)
    else $error("empty list shows entries");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) &&
                                $stable(out_taken_value) && $stable(out_occupancy))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind positional_insert_remove_list_core plist_chk u_plist_chk (.*);

### tb/positional_insert_remove_list_core_test.sv
// ----------------------------------------------------------------------------
// positional_insert_remove_list_core_test
// Drives insert and remove words into the list core with random gaps and
// output stalls, keeps a software copy of the list, and compares every status
// word field by field against the copy's prediction.
// ----------------------------------------------------------------------------
module positional_insert_remove_list_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import plist_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] taken_value;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_empty;
    logic                     is_full;
  } list_status_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_opcode;
  logic [POS_W-1:0]         in_position;
  logic signed [WORD_W-1:0] in_new_value;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_ok;
  logic signed [WORD_W-1:0] out_taken_value;
  logic signed [WORD_W-1:0] out_front_value;
  logic signed [WORD_W-1:0] out_back_value;
  logic [OCC_W-1:0]         out_occupancy;
  logic                     out_is_empty;
  logic                     out_is_full;

  // Software copy of the list
  logic signed [WORD_W-1:0] list_words [LIST_DEPTH];
  int                       list_count;
  list_status_t             pending_status_q [$];

  int idle_pct;
  int stall_pct;
  int fill_mode;
  int mismatch_count = 0;
  int status_seen = 0;
  int inserts_done;
  int removes_done;
  int refused_seen;
  int full_seen = 0;
  int empty_seen = 0;
  int cycle_count = 0;

  positional_insert_remove_list_core #(
    .DEPTH(LIST_DEPTH)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_position    (in_position),
    .in_new_value   (in_new_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ok         (out_ok),
    .out_taken_value(out_taken_value),
    .out_front_value(out_front_value),
    .out_back_value (out_back_value),
    .out_occupancy  (out_occupancy),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d status words outstanding", $time,
               pending_status_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Apply one operation to the software list and return the status it gives
  function automatic list_status_t apply_list_op(op_t op, logic [POS_W-1:0] pos,
                                                 logic signed [WORD_W-1:0] value);
    list_status_t st;
    int           p;
    int           i;
    st = '0;
    p  = int'(pos);
    if (op == OP_INSERT) begin
      if (list_count < LIST_DEPTH && p <= list_count) begin
        for (i = list_count; i > p; i--) list_words[i] = list_words[i-1];
        list_words[p] = value;
        list_count++;
        st.ok = 1'b1;
      end
    end else begin
      if (list_count > 0 && p < list_count) begin
        st.taken_value = list_words[p];
        for (i = p; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
        list_count--;
        st.ok = 1'b1;
      end
    end
    if (list_count > 0) begin
      st.front_value = list_words[0];
      st.back_value  = list_words[list_count-1];
    end
    st.occupancy = list_count[OCC_W-1:0];
    st.is_empty  = (list_count == 0);
    st.is_full   = (list_count == LIST_DEPTH);
    return st;
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a legal position for the current occupancy, now and then anything
  function automatic logic [POS_W-1:0] pick_position(op_t op);
    int top;
    top = (op == OP_INSERT) ? list_count : list_count - 1;
    if (top < 0 || top > LIST_DEPTH - 1 || $urandom_range(99) < 15)
      return POS_W'($urandom_range(LIST_DEPTH - 1));
    return POS_W'($urandom_range(top));
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    list_status_t want;
    if (rst_n && out_valid && out_ready) begin
      status_seen++;
      if (pending_status_q.size() == 0) begin
        $display("%0t: status word with none pending, expected none actual %h",
                 $time, {out_ok, out_taken_value, out_occupancy});
        mismatch_count++;
      end else begin
        want = pending_status_q.pop_front();
        check_field("ok", WORD_W'(want.ok), WORD_W'(out_ok));
        check_field("taken_value", want.taken_value, out_taken_value);
        check_field("front_value", want.front_value, out_front_value);
        check_field("back_value", want.back_value, out_back_value);
        check_field("occupancy", WORD_W'(want.occupancy), WORD_W'(out_occupancy));
        check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(out_is_empty));
        check_field("is_full", WORD_W'(want.is_full), WORD_W'(out_is_full));
        if (want.is_full) full_seen++;
        if (want.is_empty) empty_seen++;
      end
    end
  end

  // Send one word; valid stays high afterwards unless the next call idles
  task automatic send_list_op(op_t op, logic [POS_W-1:0] pos,
                              logic signed [WORD_W-1:0] value);
    list_status_t st;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_position  <= pos;
    in_new_value <= value;
    do @(posedge clk); while (!in_ready);
    st = apply_list_op(op, pos, value);
    pending_status_q.push_back(st);
    if (!st.ok) refused_seen++;
    else if (op == OP_INSERT) inserts_done++;
    else removes_done++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_op();
    op_t op;
    if (list_count == LIST_DEPTH) fill_mode = 0;
    else if (list_count == 0) fill_mode = 1;
    else if ($urandom_range(99) < 5) fill_mode = (fill_mode == 0) ? 1 : 0;
    op = (($urandom_range(99) < 75) == (fill_mode != 0)) ? OP_INSERT : OP_REMOVE;
    send_list_op(op, pick_position(op), pick_word());
  endtask

  task automatic test_empty_list();
    send_list_op(OP_REMOVE, 4'd0, 32'sh7fff_ffff);
    send_list_op(OP_REMOVE, 4'd15, 32'sh8000_0000);
    send_list_op(OP_INSERT, 4'd1, 32'sd5);
  endtask

  task automatic test_insert_positions();
    send_list_op(OP_INSERT, 4'd0, 32'sh8000_0000);
    send_list_op(OP_INSERT, 4'd1, 32'sh7fff_ffff);   // append at back
    send_list_op(OP_INSERT, 4'd1, -32'sd1);           // middle
    send_list_op(OP_INSERT, 4'd0, 32'sd0);            // new front
    send_list_op(OP_INSERT, 4'd6, 32'sd77);           // beyond occupancy
    send_list_op(OP_REMOVE, 4'd4, 32'sd0);            // unoccupied
    send_list_op(OP_REMOVE, 4'd1, 32'sd0);
  endtask

  task automatic test_full_list();
    while (list_count < LIST_DEPTH)
      send_list_op(OP_INSERT, POS_W'($urandom_range(list_count)), pick_word());
    send_list_op(OP_INSERT, 4'd0, 32'sd1);
    send_list_op(OP_INSERT, 4'd15, 32'sd2);
    send_list_op(OP_REMOVE, 4'd15, 32'sd0);
    send_list_op(OP_REMOVE, 4'd0, 32'sd0);
  endtask

  task automatic test_random_walk(int n);
    repeat (n) send_random_op();
  endtask

  // Sender holds off until the core has answered everything, then resumes
  task automatic test_drain_pause();
    repeat (3) begin
      repeat (20) send_random_op();
      wait_for_results();
    end
  endtask

  task automatic test_back_to_back();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (120) send_random_op();
    idle_pct  = 31;
    stall_pct = 31;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_INSERT;
    in_position    = '0;
    in_new_value   = '0;
    idle_pct       = 31;
    stall_pct      = 31;
    fill_mode      = 1;
    list_count     = 0;
    inserts_done   = 0;
    removes_done   = 0;
    refused_seen   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_insert_positions();
    test_full_list();
    test_random_walk(250);
    test_drain_pause();
    test_back_to_back();
    test_random_walk(40);

    wait_for_results();
    repeat (4) @(posedge clk);
    $display("Checked %0d status words: %0d inserts, %0d removes, %0d refusals",
             status_seen, inserts_done, removes_done, refused_seen);
    $display("List seen full %0d times and empty %0d times", full_seen, empty_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
